// ===== hdl/bqlp_pkg.sv =====
package bqlp_pkg;

   // Sample format and the packing of the stream words.
   localparam int SAMPLE_WIDTH = 24;
   localparam int SAMPLE_SHIFT = 32 - SAMPLE_WIDTH;
   localparam int CUT_W        = 21;
   localparam int Q_W          = 13;
   localparam int RATE_W       = 19;
   localparam int SMOOTH_W     = 16;
   localparam int CMAX_W       = 22;
   localparam int REQ_DATA_W   = ((SAMPLE_WIDTH + CUT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 21;

   // Register indexes on the control port.
   localparam logic [CSR_IDX_W-1:0] CSR_RATE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_DEF    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_INPUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Q          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH     = 3'd4;

   // Bit-serial divider.
   localparam int DIV_NUM_W = 61;
   localparam int DIV_DEN_W = 36;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // Two-pass multiplier: magnitude of a times magnitude of b.
   localparam int MUL_A_W   = 36;
   localparam int MUL_B_W   = 42;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_SPLIT = 20;
   localparam int MUL_HI_W  = MUL_B_W - MUL_SPLIT;

   // Rotator.
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_ITERS = 24;
   localparam int CORDIC_IDX_W = $clog2(CORDIC_ITERS);
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] iters;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // Arctangent of 2^-i in Q2.30 radians.
   function automatic logic [31:0] cordic_atan(input logic [CORDIC_IDX_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'd843314857;
         5'd1:    v = 32'd497837829;
         5'd2:    v = 32'd263043837;
         5'd3:    v = 32'd133525159;
         5'd4:    v = 32'd67021687;
         5'd5:    v = 32'd33543516;
         5'd6:    v = 32'd16775851;
         5'd7:    v = 32'd8388437;
         5'd8:    v = 32'd4194283;
         5'd9:    v = 32'd2097149;
         5'd10:   v = 32'd1048576;
         5'd11:   v = 32'd524288;
         5'd12:   v = 32'd262144;
         5'd13:   v = 32'd131072;
         5'd14:   v = 32'd65536;
         5'd15:   v = 32'd32768;
         5'd16:   v = 32'd16384;
         5'd17:   v = 32'd8192;
         5'd18:   v = 32'd4096;
         5'd19:   v = 32'd2048;
         5'd20:   v = 32'd1024;
         5'd21:   v = 32'd512;
         5'd22:   v = 32'd256;
         5'd23:   v = 32'd128;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/biquad_lowpass_smoothed_cutoff.sv =====
// One sample is in work at a time: no new req beat is taken until the
// result of the last one is queued, and a held-off rsp beat holds the
// sequencer in its output state for as long as the hold-off lasts.
// The time per sample is set mostly by the bit-serial divider (150 quotient
// bits over three divisions), then the 24-step rotator and eleven two-pass multiplies.
// Reset (synchronous, active high) restores the register defaults, clears
// the filter delays and marks the tracked cutoff and Q as not yet started.
module biquad_lowpass_smoothed_cutoff import bqlp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata fields, lowest bit first: sample_in, cutoff_in.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata fields, lowest bit first: sample_out.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // The sequencer walks one sample through the shared divider, multiplier
   // and rotator. Each arithmetic state issues its operation once and moves
   // on when the unit reports done.
   typedef enum logic [4:0] {
      S_IDLE, S_CMAX, S_LOAD, S_SMC, S_SMQ, S_PH, S_Z, S_ROT, S_ALPHA, S_INV,
      S_B0, S_B1, S_A1, S_A2, S_Y, S_T1, S_T2, S_T3, S_OUT
   } state_type;

   localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(48000);
   localparam logic signed [MUL_A_W-1:0] ONE_Q30_A = MUL_A_W'(64'd1 << 30);
   localparam logic [MUL_B_W-1:0] PI_Q30_B = MUL_B_W'(64'd3373259426);
   localparam logic signed [40:0] OUT_HALF = 41'((64'd1 << SAMPLE_SHIFT) >> 1);
   localparam logic signed [40:0] OUT_MAX = 41'((64'd1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [40:0] OUT_MIN = -41'sd1 - OUT_MAX;
   // The cutoff bound is rate * 196 / 25. The factor is 196 * ceil(2^32 / 25);
   // taking the product down by 32 bits gives the exact floor for any
   // rate * 196 below 2^30, which covers every rate the register can hold.
   localparam logic [53:0] CMAX_RECIP = 54'd33672543632;

   state_type                 state_ff, state_in;
   logic                      issued_ff, issued_in;

   // Configuration registers.
   logic [RATE_W-1:0]         reg_rate_ff;
   logic [CUT_W-1:0]          reg_cut_def_ff;
   logic                      reg_use_in_ff;
   logic [Q_W-1:0]            reg_q_ff;
   logic [SMOOTH_W-1:0]       reg_smooth_ff;

   // Filter and smoother state.
   logic signed [39:0]        d1_ff, d2_ff;
   logic [CUT_W-1:0]          trk_cut_ff;
   logic [Q_W-1:0]            trk_q_ff;

   // Per-sample working registers.
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [CUT_W-1:0]          cut_in_ff, tcut_ff;
   logic [Q_W-1:0]            tq_ff;
   logic [CMAX_W-1:0]         cmax_ff;
   logic [30:0]               ph_ff;
   logic                      fold_ff;
   logic signed [CORDIC_W-1:0] z_ff;
   logic [DIV_DEN_W-1:0]      alpha_ff;
   logic [31:0]               inv_ff;
   logic signed [MUL_A_W-1:0] b0_ff, b1_ff, a1_ff, a2_ff;
   logic signed [47:0]        t0_ff, t1_ff;
   logic signed [39:0]        yo_ff;
   logic                      rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0]   rsp_sample_ff;

   // Shared unit hookup.
   div_ctl_type               div_ctl;
   logic                      div_start;
   logic [DIV_CNT_W-1:0]      div_iters;
   logic [DIV_NUM_W-1:0]      div_num;
   logic [DIV_DEN_W-1:0]      div_den;
   unit_sts_type              div_sts;
   logic [DIV_NUM_W-1:0]      div_quo;
   logic                      mul_start;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   unit_sts_type              mul_sts;
   logic [MUL_P_W-1:0]        mul_mag;
   logic                      mul_neg;
   logic                      rot_start;
   unit_sts_type              rot_sts;
   logic signed [CORDIC_W-1:0] rot_x, rot_y;

   // Derived values.
   logic [RATE_W-1:0]         rate;
   logic [53:0]               cmax_prod;
   logic [CUT_W-1:0]          cut_now;
   logic [Q_W-1:0]            q_now;
   logic signed [MUL_P_W-1:0] prod;
   logic signed [47:0]        mq;
   logic signed [MUL_P_W-1:0] smooth_step;
   logic signed [CORDIC_W-1:0] cos_v, sin_pos;
   logic signed [31:0]        xs;
   logic [31:0]               ph_cap;
   logic                      unit_done;
   logic                      item_accept;

   function automatic logic [CUT_W-1:0] clamp_cut(input logic [CUT_W-1:0] v,
                                                  input logic [CMAX_W-1:0] hi);
      logic [CUT_W-1:0] r;
      if (v < CUT_W'(16)) begin
         r = CUT_W'(16);
      end else if ({1'b0, v} > hi) begin
         r = hi[CUT_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [Q_W-1:0] clamp_q(input logic [Q_W-1:0] v);
      logic [Q_W-1:0] r;
      if (v < Q_W'(13)) begin
         r = Q_W'(13);
      end else if (v > Q_W'(5120)) begin
         r = Q_W'(5120);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Product scaled by 2^-30, rounded to nearest with ties away from zero.
   function automatic logic signed [47:0] round_q30(input logic [MUL_P_W-1:0] m,
                                                    input logic n);
      logic [47:0] r;
      r = 48'((m + (MUL_P_W'(1) << 29)) >> 30);
      return n ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [49:0] v);
      logic signed [39:0] r;
      if (v > 50'sh7F_FFFF_FFFF) begin
         r = 40'sh7F_FFFF_FFFF;
      end else if (v < -50'sh80_0000_0000) begin
         r = -40'sh80_0000_0000;
      end else begin
         r = 40'(v);
      end
      return r;
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] out_sat(input logic signed [39:0] v);
      logic signed [40:0] o;
      o = (41'(v) + OUT_HALF) >>> SAMPLE_SHIFT;
      if (o > OUT_MAX) o = OUT_MAX;
      if (o < OUT_MIN) o = OUT_MIN;
      return o[SAMPLE_WIDTH-1:0];
   endfunction

   always_comb begin
      rate        = (reg_rate_ff > RATE_W'(1)) ? reg_rate_ff : DEFAULT_RATE;
      cmax_prod   = 54'(rate) * CMAX_RECIP;
      cut_now     = clamp_cut(trk_cut_ff, cmax_ff);
      q_now       = clamp_q(trk_q_ff);
      prod        = mul_neg ? -$signed(mul_mag) : $signed(mul_mag);
      mq          = round_q30(mul_mag, mul_neg);
      smooth_step = (prod + MUL_P_W'(32768)) >>> 16;
      cos_v       = fold_ff ? -rot_x : rot_x;
      sin_pos     = rot_y[CORDIC_W-1] ? '0 : rot_y;
      xs          = 32'(sample_ff) <<< SAMPLE_SHIFT;
      ph_cap      = (div_quo > DIV_NUM_W'(64'd1 << 31)) ? 32'h8000_0000
                                                        : div_quo[31:0];
      item_accept = req_tvalid && req_tready;
   end

   // Operand selection for the shared units.
   always_comb begin
      div_iters = '0;
      div_num   = '0;
      div_den   = '0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_PH: begin
            div_iters = DIV_CNT_W'(49);
            div_num = DIV_NUM_W'({cut_now, 28'd0} + 49'(rate >> 1)) << (DIV_NUM_W - 49);
            div_den = DIV_DEN_W'(rate);
         end
         S_ALPHA: begin
            div_iters = DIV_CNT_W'(40);
            div_num = DIV_NUM_W'({sin_pos[32:0], 7'd0}) << (DIV_NUM_W - 40);
            div_den = DIV_DEN_W'(q_now);
         end
         S_INV: begin
            div_iters = DIV_CNT_W'(DIV_NUM_W);
            div_num = DIV_NUM_W'(64'd1 << 60);
            div_den = DIV_DEN_W'(64'd1 << 30) + alpha_ff;
         end
         S_SMC: begin
            mul_a = MUL_A_W'(reg_smooth_ff);
            mul_b = MUL_B_W'($signed({1'b0, trk_cut_ff}) - $signed({1'b0, tcut_ff}));
         end
         S_SMQ: begin
            mul_a = MUL_A_W'(reg_smooth_ff);
            mul_b = MUL_B_W'($signed({1'b0, trk_q_ff}) - $signed({1'b0, tq_ff}));
         end
         S_Z: begin
            mul_a = MUL_A_W'(ph_ff);
            mul_b = PI_Q30_B;
         end
         S_B0: begin
            mul_a = (ONE_Q30_A - MUL_A_W'(cos_v)) >>> 1;
            mul_b = MUL_B_W'(inv_ff);
         end
         S_B1: begin
            mul_a = ONE_Q30_A - MUL_A_W'(cos_v);
            mul_b = MUL_B_W'(inv_ff);
         end
         S_A1: begin
            mul_a = -(MUL_A_W'(cos_v) <<< 1);
            mul_b = MUL_B_W'(inv_ff);
         end
         S_A2: begin
            mul_a = ONE_Q30_A - $signed(alpha_ff);
            mul_b = MUL_B_W'(inv_ff);
         end
         S_Y, S_T1: begin
            mul_a = (state_ff == S_Y) ? b0_ff : b1_ff;
            mul_b = MUL_B_W'(xs);
         end
         S_T2, S_T3: begin
            mul_a = (state_ff == S_T2) ? a1_ff : a2_ff;
            mul_b = MUL_B_W'(yo_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      mul_start = 1'b0;
      rot_start = 1'b0;
      unit_done = 1'b0;
      case (state_ff)
         S_PH, S_ALPHA, S_INV: begin
            div_start = !issued_ff;
            unit_done = issued_ff && div_sts.done;
         end
         S_ROT: begin
            rot_start = !issued_ff;
            unit_done = issued_ff && rot_sts.done;
         end
         S_SMC, S_SMQ, S_Z, S_B0, S_B1, S_A1, S_A2, S_Y, S_T1, S_T2, S_T3: begin
            mul_start = !issued_ff;
            unit_done = issued_ff && mul_sts.done;
         end
         default: ;
      endcase
      issued_in = unit_done ? 1'b0 : (issued_ff || div_start || mul_start || rot_start);
   end

   assign div_ctl = '{start: div_start, iters: div_iters};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (item_accept) state_in = S_CMAX;
         S_CMAX:  state_in = S_LOAD;
         S_LOAD:  state_in = S_SMC;
         S_SMC:   if (unit_done) state_in = S_SMQ;
         S_SMQ:   if (unit_done) state_in = S_PH;
         S_PH:    if (unit_done) state_in = S_Z;
         S_Z:     if (unit_done) state_in = S_ROT;
         S_ROT:   if (unit_done) state_in = S_ALPHA;
         S_ALPHA: if (unit_done) state_in = S_INV;
         S_INV:   if (unit_done) state_in = S_B0;
         S_B0:    if (unit_done) state_in = S_B1;
         S_B1:    if (unit_done) state_in = S_A1;
         S_A1:    if (unit_done) state_in = S_A2;
         S_A2:    if (unit_done) state_in = S_Y;
         S_Y:     if (unit_done) state_in = S_T1;
         S_T1:    if (unit_done) state_in = S_T2;
         S_T2:    if (unit_done) state_in = S_T3;
         S_T3:    if (unit_done) state_in = S_OUT;
         S_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control state, configuration and the state that reset defines.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         issued_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         reg_rate_ff    <= RATE_W'(48000);
         reg_cut_def_ff <= CUT_W'(16000);
         reg_use_in_ff  <= 1'b0;
         reg_q_ff       <= Q_W'(181);
         reg_smooth_ff  <= '0;
         d1_ff          <= '0;
         d2_ff          <= '0;
         trk_cut_ff     <= '0;
         trk_q_ff       <= '0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;

         if (csr_valid) begin
            unique case (csr_index)
               CSR_RATE:      reg_rate_ff    <= csr_data[RATE_W-1:0];
               CSR_CUT_DEF:   reg_cut_def_ff <= csr_data[CUT_W-1:0];
               CSR_USE_INPUT: reg_use_in_ff  <= csr_data[0];
               CSR_Q:         reg_q_ff       <= csr_data[Q_W-1:0];
               CSR_SMOOTH:    reg_smooth_ff  <= csr_data[SMOOTH_W-1:0];
               default: ;
            endcase
         end

         // A tracker at zero has not started and jumps to its setting.
         if (state_ff == S_LOAD) begin
            if (trk_cut_ff == '0) trk_cut_ff <= clamp_cut(reg_cut_def_ff, cmax_ff);
            if (trk_q_ff == '0) trk_q_ff <= clamp_q(reg_q_ff);
         end
         if (state_ff == S_SMC && unit_done) begin
            trk_cut_ff <= smooth_step[CUT_W-1:0] + tcut_ff;
         end
         if (state_ff == S_SMQ && unit_done) begin
            trk_q_ff <= smooth_step[Q_W-1:0] + tq_ff;
         end
         if (state_ff == S_T2 && unit_done) begin
            d1_ff <= sat40(50'(t1_ff) - 50'(mq) + 50'(d2_ff));
         end
         if (state_ff == S_T3 && unit_done) begin
            d2_ff <= sat40(50'(t0_ff) - 50'(mq));
         end

         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers; they carry no meaning between samples.
   always_ff @(posedge clock) begin
      if (item_accept) begin
         sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         cut_in_ff <= req_tdata[SAMPLE_WIDTH+CUT_W-1:SAMPLE_WIDTH];
      end
      if (state_ff == S_CMAX) cmax_ff <= cmax_prod[CMAX_W+31:32];
      if (state_ff == S_LOAD) begin
         tcut_ff <= clamp_cut(reg_use_in_ff ? cut_in_ff : reg_cut_def_ff, cmax_ff);
         tq_ff   <= clamp_q(reg_q_ff);
      end
      // Cap at half a turn, then fold the second quarter onto the first.
      if (state_ff == S_PH && unit_done) begin
         fold_ff <= ph_cap > 32'h4000_0000;
         ph_ff   <= (ph_cap > 32'h4000_0000) ? 31'(32'h8000_0000 - ph_cap) : ph_cap[30:0];
      end
      if (state_ff == S_Z && unit_done) begin
         z_ff <= CORDIC_W'((mul_mag + (MUL_P_W'(1) << 30)) >> 31);
      end
      if (state_ff == S_ALPHA && unit_done) alpha_ff <= div_quo[DIV_DEN_W-1:0];
      if (state_ff == S_INV && unit_done) inv_ff <= div_quo[31:0];
      if (state_ff == S_B0 && unit_done) b0_ff <= MUL_A_W'(mq);
      if (state_ff == S_B1 && unit_done) b1_ff <= MUL_A_W'(mq);
      if (state_ff == S_A1 && unit_done) a1_ff <= MUL_A_W'(mq);
      if (state_ff == S_A2 && unit_done) a2_ff <= MUL_A_W'(mq);
      if (state_ff == S_Y && unit_done) begin
         t0_ff <= mq;
         yo_ff <= sat40(50'(mq) + 50'(d1_ff));
      end
      if (state_ff == S_T1 && unit_done) t1_ff <= mq;
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_sample_ff <= out_sat(yo_ff);
      end
   end

   bqlp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_num),
      .divisor  (div_den),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   bqlp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .sts   (mul_sts),
      .mag   (mul_mag),
      .neg   (mul_neg)
   );

   bqlp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (rot_start),
      .angle   (z_ff),
      .sts     (rot_sts),
      .cos_out (rot_x),
      .sin_out (rot_y)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_sample_ff);
   assign csr_ready  = 1'b1;

   // Once a sample is taken, no other is taken until its result is queued.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      item_accept |=> !req_tready)
      else $error("second sample accepted while one is in work");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> (!mul_sts.busy && !div_sts.busy && !rot_sts.busy))
      else $error("multiplier started while a unit is busy");

   a_result_queued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) |=>
         (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished sample was not queued for output");

endmodule

// ===== hdl/bqlp_div.sv =====
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned so that only the requested number of bits is walked.
module bqlp_div import bqlp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctl_type          ctl,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output unit_sts_type         sts,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 busy_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff, quo_ff;
   logic [DIV_DEN_W-1:0] den_ff, rem_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;
   logic [DIV_DEN_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ctl.iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start && !busy_ff) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[DIV_NUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/bqlp_mul.sv =====
// Sign-magnitude multiplier that forms the product in two passes through one
// narrow array: low slice of b first, then the high slice shifted up.
module bqlp_mul import bqlp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output unit_sts_type              sts,
   output logic [MUL_P_W-1:0]        mag,
   output logic                      neg
);

   typedef enum logic [1:0] {MS_IDLE, MS_LO, MS_HI} mstate_type;

   mstate_type                 state_ff;
   logic                       done_ff;
   logic [MUL_A_W-1:0]         ua_ff;
   logic [MUL_B_W-1:0]         ub_ff;
   logic                       neg_ff;
   logic [MUL_P_W-1:0]         acc_ff;
   logic [MUL_HI_W-1:0]        slice;
   logic [MUL_A_W+MUL_HI_W-1:0] partial;

   always_comb begin
      slice   = (state_ff == MS_LO) ? MUL_HI_W'(ub_ff[MUL_SPLIT-1:0])
                                    : ub_ff[MUL_B_W-1:MUL_SPLIT];
      partial = (MUL_A_W + MUL_HI_W)'(ua_ff) * (MUL_A_W + MUL_HI_W)'(slice);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            MS_IDLE: if (start) state_ff <= MS_LO;
            MS_LO:   state_ff <= MS_HI;
            MS_HI: begin
               state_ff <= MS_IDLE;
               done_ff  <= 1'b1;
            end
            default: state_ff <= MS_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == MS_IDLE && start) begin
         ua_ff  <= op_a[MUL_A_W-1] ? MUL_A_W'(-op_a) : MUL_A_W'(op_a);
         ub_ff  <= op_b[MUL_B_W-1] ? MUL_B_W'(-op_b) : MUL_B_W'(op_b);
         neg_ff <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
      end
      if (state_ff == MS_LO) begin
         acc_ff <= MUL_P_W'(partial);
      end else if (state_ff == MS_HI) begin
         acc_ff <= acc_ff + (MUL_P_W'(partial) << MUL_SPLIT);
      end
   end

   assign sts.busy = (state_ff != MS_IDLE);
   assign sts.done = done_ff;
   assign mag      = acc_ff;
   assign neg      = neg_ff;

endmodule

// ===== hdl/bqlp_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle through adders for x, y
// and the angle, and one shifter each for x and y.
module bqlp_cordic import bqlp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [CORDIC_W-1:0] angle,
   output unit_sts_type               sts,
   output logic signed [CORDIC_W-1:0] cos_out,
   output logic signed [CORDIC_W-1:0] sin_out
);

   logic                        busy_ff, done_ff;
   logic [CORDIC_IDX_W-1:0]     iter_ff;
   logic signed [CORDIC_W-1:0]  x_ff, y_ff, z_ff;
   logic signed [CORDIC_W-1:0]  dx, dy, da;

   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      da = CORDIC_W'(cordic_atan(iter_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == CORDIC_IDX_W'(CORDIC_ITERS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         x_ff <= CORDIC_GAIN;
         y_ff <= '0;
         z_ff <= angle;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - da;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + da;
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign cos_out  = x_ff;
   assign sin_out  = y_ff;

endmodule
